// ===== rtl/variable_step_lowpass_filter_assert.svh =====
// Assertion macros shared by the low-pass filter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VARIABLE_STEP_LOWPASS_FILTER_ASSERT_SVH
`define VARIABLE_STEP_LOWPASS_FILTER_ASSERT_SVH

// same-cycle implication
`define VSLPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSLPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vslpf_pkg.sv =====
// Shared types and constants of the variable-step low-pass filter.
// No dependencies.
package vslpf_pkg;

  localparam int STAMP_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int TAU_W    = 24;
  localparam int CHANNELS = 4;

  localparam logic [TAU_W-1:0] TAU_RESET = 24'd1000;

  // gain is Q0.16 with 1.0 representable -> 17 quotient bits
  localparam int FRAC_W = 16;
  localparam int Q_BITS = FRAC_W + 1;
  localparam int CNT_W  = $clog2(Q_BITS);
  localparam int DEN_W  = STAMP_W + 1;
  localparam int NUM_W  = STAMP_W + FRAC_W + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int ACC_W  = DIFF_W + Q_BITS;

  // sequencing strobes from the control FSM
  typedef struct packed {
    logic accept;  // new word taken
    logic prep;    // form denominator
    logic load;    // load dividend
    logic step;    // one quotient bit
    logic fin;     // commit filtered values
  } ctl_t;

endpackage

// ===== rtl/vslpf_div.sv =====
// Bit-serial restoring divider for the gain alpha = round(dt*2^16 / (dt+tau)).
// Emits one quotient bit per step, MSB first. Uses vslpf_pkg.
module vslpf_div
  import vslpf_pkg::*;
(
  input  logic               clk,
  input  ctl_t               ctl,
  input  logic [STAMP_W-1:0] dt,
  input  logic [TAU_W-1:0]   tau,
  output logic               q_bit
);

  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [Q_BITS-1:0] low_r;
  logic              zero_r;
  logic [NUM_W-1:0]  num;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;

  // dividend = dt*2^16 + floor(den/2)
  assign num     = {1'b0, dt, {FRAC_W{1'b0}}} + NUM_W'(den_r[DEN_W-1:1]);
  assign shifted = {rem_r, low_r[Q_BITS-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign q_bit   = !trial[DEN_W] && !zero_r;

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      den_r <= DEN_W'(dt) + DEN_W'(tau);
    end
    if (ctl.load) begin
      rem_r  <= DEN_W'(num[NUM_W-1:Q_BITS]);
      low_r  <= num[Q_BITS-1:0];
      zero_r <= (den_r == '0);
    end else if (ctl.step) begin
      rem_r <= q_bit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      low_r <= {low_r[Q_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/vslpf_lane.sv =====
// One filter channel: MSB-first serial multiply of alpha by (x - y),
// then rounded update and clamp of the held value. Uses vslpf_pkg.
module vslpf_lane
  import vslpf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctl_t                       ctl,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic                       q_bit,
  output logic signed [SAMPLE_W-1:0] y
);

  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [SAMPLE_W-1:0] y_nxt;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W:0]      sum;
  logic signed [ACC_W-FRAC_W:0] res;

  // y + floor((acc + 2^15) / 2^16) in one add
  assign sum = (ACC_W+1)'(acc_r)
             + (ACC_W+1)'($signed({y_r, 1'b1, {(FRAC_W-1){1'b0}}}));
  assign res = sum[ACC_W:FRAC_W];

  always_comb begin
    if (res[ACC_W-FRAC_W:SAMPLE_W-1] == '0 || res[ACC_W-FRAC_W:SAMPLE_W-1] == '1) begin
      y_nxt = res[SAMPLE_W-1:0];
    end else begin
      y_nxt = res[ACC_W-FRAC_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      diff_r <= DIFF_W'(x) - DIFF_W'(y_r);
      acc_r  <= '0;
    end else if (ctl.step) begin
      acc_r <= (acc_r <<< 1) + (q_bit ? ACC_W'(diff_r) : ACC_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
    end else if (ctl.fin) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/variable_step_lowpass_filter.sv =====
// Variable-step first-order low-pass filter over CHANNELS signed samples.
// Depends on vslpf_pkg, vslpf_div, vslpf_lane and the assertion macro header.
//
// Usage:
//  - cfg_*: write tau (cfg_time_constant) with cfg_valid; cfg_ready is always
//    high. Write only while no word is in flight. tau resets to 1000.
//  - in_*: a timestamped sample word is taken when in_valid && !in_stall.
//    The step dt is in_timestamp minus the previous timestamp, modulo 2^32.
//  - out_*: one filtered word per input word, taken when out_valid &&
//    !out_stall; out_stamp_out repeats the input timestamp.
// Timing: out_valid is registered and set by the commit. The accepting edge
//  captures dt and x - y; then dt + tau is formed, the dividend is loaded,
//  the serial divider runs (one gain bit per cycle, fed straight into the
//  lanes' serial multipliers) and the values are committed. The next word is
//  accepted in the cycle after commit at the earliest, so a word is committed
//  before the next one enters.
// Stall: the held state doubles as output register. A new word may be
//  accepted and worked on while out_valid waits; it holds at the commit step
//  until the waiting word is taken.
// Reset (rst_n, synchronous): held values zero, last timestamp zero.
module variable_step_lowpass_filter
  import vslpf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [TAU_W-1:0]           cfg_time_constant,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [STAMP_W-1:0]         in_timestamp,
  input  logic signed [SAMPLE_W-1:0] in_sample_0,
  input  logic signed [SAMPLE_W-1:0] in_sample_1,
  input  logic signed [SAMPLE_W-1:0] in_sample_2,
  input  logic signed [SAMPLE_W-1:0] in_sample_3,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STAMP_W-1:0]         out_stamp_out,
  output logic signed [SAMPLE_W-1:0] out_filtered_0,
  output logic signed [SAMPLE_W-1:0] out_filtered_1,
  output logic signed [SAMPLE_W-1:0] out_filtered_2,
  output logic signed [SAMPLE_W-1:0] out_filtered_3
);

`include "variable_step_lowpass_filter_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_BITS - 1);

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TAU_W-1:0]    tau_r;
  logic [STAMP_W-1:0]  dt_r;
  logic [STAMP_W-1:0]  stamp_r;      // stamp of word in flight
  logic [STAMP_W-1:0]  last_stamp_r; // stamp of last committed word
  logic                out_valid_r;
  logic                q_bit;
  ctl_t                ctl;

  logic signed [SAMPLE_W-1:0] x [CHANNELS];
  logic signed [SAMPLE_W-1:0] y [CHANNELS];

  assign x[0] = in_sample_0;
  assign x[1] = in_sample_1;
  assign x[2] = in_sample_2;
  assign x[3] = in_sample_3;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);

  // strobes
  assign ctl.accept = in_valid && !in_stall;
  assign ctl.prep   = (state_r == S_PREP);
  assign ctl.load   = (state_r == S_LOAD);
  assign ctl.step   = (state_r == S_DIV);
  assign ctl.fin    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r <= TAU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tau_r <= cfg_time_constant;
    end
  end

  // control FSM and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      last_stamp_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.accept) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (ctl.fin) begin
            last_stamp_r <= stamp_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // commit raises valid; a taken word without a commit clears it
      if (ctl.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload captured on acceptance
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      dt_r    <= in_timestamp - last_stamp_r;
      stamp_r <= in_timestamp;
    end
  end

  vslpf_div u_div (
    .clk   (clk),
    .ctl   (ctl),
    .dt    (dt_r),
    .tau   (tau_r),
    .q_bit (q_bit)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    vslpf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .x     (x[i]),
      .q_bit (q_bit),
      .y     (y[i])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_stamp_out  = last_stamp_r;
  assign out_filtered_0 = y[0];
  assign out_filtered_1 = y[1];
  assign out_filtered_2 = y[2];
  assign out_filtered_3 = y[3];

  `VSLPF_ASSERT_NOW(a_fin_no_overwrite, ctl.fin, !(out_valid_r && out_stall), "commit over stalled word")
  `VSLPF_ASSERT_NEXT(a_accept_busy, ctl.accept, in_stall && state_r == S_PREP, "accept did not start work")
  `VSLPF_ASSERT_NEXT(a_div_len, state_r == S_DIV && cnt_r == CNT_LAST, state_r == S_FIN, "divider length wrong")
  `VSLPF_ASSERT_NOW(a_valid_from_fin, $rose(out_valid_r), $past(ctl.fin), "output valid without commit")

endmodule

// ===== sim/variable_step_lowpass_filter_tb.sv =====
// Self-checking testbench for variable_step_lowpass_filter: directed rows, then random phases.
// Each phase has its own time constant; a bit-exact predictor checks all words but typed rows.
// Depends on vslpf_pkg and the filter RTL only.
module variable_step_lowpass_filter_tb;
  import vslpf_pkg::*;

  localparam logic [SAMPLE_W-1:0] S_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] S_MIN = 16'h8000;
  localparam logic [TAU_W-1:0]    TAU_MAX = 24'hFF_FFFF;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 172;

  // one filtered word as it leaves the block
  typedef struct packed {
    logic [STAMP_W-1:0]                 stamp;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  val;
  } word_t;

  // directed stimulus row; want is used only when typed is set
  typedef struct {
    bit                                set_tau;
    logic [TAU_W-1:0]                  tau;
    logic [STAMP_W-1:0]                stamp;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] x;
    bit                                typed;
    word_t                             want;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [TAU_W-1:0]           cfg_time_constant;
  logic                       in_valid;
  logic                       in_stall;
  logic [STAMP_W-1:0]         in_timestamp;
  logic signed [SAMPLE_W-1:0] in_sample_0, in_sample_1, in_sample_2, in_sample_3;
  logic                       out_valid;
  logic                       out_stall;
  logic [STAMP_W-1:0]         out_stamp_out;
  logic signed [SAMPLE_W-1:0] out_filtered_0, out_filtered_1, out_filtered_2, out_filtered_3;

  variable_step_lowpass_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_time_constant (cfg_time_constant),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_timestamp      (in_timestamp),
    .in_sample_0       (in_sample_0),
    .in_sample_1       (in_sample_1),
    .in_sample_2       (in_sample_2),
    .in_sample_3       (in_sample_3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stamp_out     (out_stamp_out),
    .out_filtered_0    (out_filtered_0),
    .out_filtered_1    (out_filtered_1),
    .out_filtered_2    (out_filtered_2),
    .out_filtered_3    (out_filtered_3)
  );

  always #1 clk = ~clk;

  // predictor state: a private copy of tau, the held outputs and the last stamp
  logic [TAU_W-1:0]           tau_now;
  logic signed [SAMPLE_W-1:0] held_y [CHANNELS];
  logic [STAMP_W-1:0]         prev_stamp;

  word_t pending_smoothed[$];   // expected words, oldest first
  word_t seen, due, predicted;
  bit    row_typed;             // travels with the payload on the input side
  word_t row_want;
  row_t  plan[$];

  int errors     = 0;
  int words_sent = 0;
  int typed_sent = 0;
  int words_seen = 0;
  int tau_writes = 0;

  // idle control: quiet turns all idling off, the calm flags make idle-free stretches
  bit quiet      = 1'b0;
  bit send_calm  = 1'b0;
  bit drain_calm = 1'b0;
  int hold_left  = 0;

  // Q0.16 gain dt/(dt+tau), rounded half up; 65536 stands for 1.0
  function automatic logic [Q_BITS-1:0] step_gain(input logic [STAMP_W-1:0] dt,
                                                  input logic [TAU_W-1:0] tau);
    logic [DEN_W-1:0] den;
    logic [48:0]      num;
    den = {1'b0, dt} + {9'd0, tau};
    if (den == '0) return '0;   // tau 0 and dt 0: hold
    num = {1'b0, dt, 16'd0} + {17'd0, den[DEN_W-1:1]};
    return Q_BITS'(num / {16'd0, den});
  endfunction

  // y + floor((g*(x-y) + 0.5) / 1.0), clamped to the sample range
  function automatic logic signed [SAMPLE_W-1:0] lane_next(input logic signed [SAMPLE_W-1:0] y,
                                                           input logic signed [SAMPLE_W-1:0] x,
                                                           input logic [Q_BITS-1:0] g);
    longint prod, r;
    prod = longint'(g) * (longint'(x) - longint'(y)) + 64'sd32768;
    r = longint'(y) + (prod >>> 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return SAMPLE_W'(r);
  endfunction

  // advance the predictor by one accepted input word
  function automatic word_t smooth_vector(input logic [STAMP_W-1:0] stamp,
                                          input logic [CHANNELS-1:0][SAMPLE_W-1:0] x);
    logic [Q_BITS-1:0] g;
    word_t w;
    g = step_gain(stamp - prev_stamp, tau_now);
    for (int k = 0; k < CHANNELS; k++) begin
      held_y[k] = lane_next(held_y[k], x[k], g);
      w.val[k] = held_y[k];
    end
    prev_stamp = stamp;
    w.stamp = stamp;
    return w;
  endfunction

  // random sample: extremes, a wander around the previous value, or anything
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic signed [SAMPLE_W-1:0] prev);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0:       return S_MAX;
        1:       return S_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 60) begin
      v = int'(prev) + int'($urandom_range(0, 1024)) - 512;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return SAMPLE_W'(v);
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic plan_row(input bit st, input logic [TAU_W-1:0] tau,
                          input logic [STAMP_W-1:0] stamp,
                          input int x0, input int x1, input int x2, input int x3,
                          input bit typed, input int w0, input int w1, input int w2,
                          input int w3);
    row_t r;
    r.set_tau = st;
    r.tau     = tau;
    r.stamp   = stamp;
    r.x       = {16'(x3), 16'(x2), 16'(x1), 16'(x0)};
    r.typed   = typed;
    r.want.stamp = stamp;
    r.want.val   = {16'(w3), 16'(w2), 16'(w1), 16'(w0)};
    plan.push_back(r);
  endtask

  task automatic report(input string what, input word_t want, input word_t got);
    errors++;
    if (errors <= 10)
      $display("tb: %s at %0t: want stamp %h y %0d %0d %0d %0d, got stamp %h y %0d %0d %0d %0d",
               what, $realtime, want.stamp,
               $signed(want.val[0]), $signed(want.val[1]),
               $signed(want.val[2]), $signed(want.val[3]), got.stamp,
               $signed(got.val[0]), $signed(got.val[1]),
               $signed(got.val[2]), $signed(got.val[3]));
  endtask

  // Drive one word at the falling edge, hold it until accepted, then maybe idle.
  // Without a gap, valid stays high and the next call swaps the payload.
  task automatic push_word(input logic [STAMP_W-1:0] stamp,
                           input logic [CHANNELS-1:0][SAMPLE_W-1:0] x,
                           input bit typed, input word_t want);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_timestamp <= stamp;
    in_sample_0  <= x[0];
    in_sample_1  <= x[1];
    in_sample_2  <= x[2];
    in_sample_3  <= x[3];
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (typed) typed_sent++;
    if (!quiet && !send_calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_smoothed.size() != 0) @(posedge clk);
  endtask

  // tau is written only with nothing in flight
  task automatic load_tau(input logic [TAU_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_time_constant <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    tau_writes++;
  endtask

  // Result side: stall bursts of random length, with calm stretches, none when quiet.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) drain_calm = !drain_calm;
      if (hold_left == 0 && !quiet && !drain_calm && $urandom_range(0, 11) == 0)
        hold_left = $urandom_range(1, 18);
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  // Monitor: everything sampled at the rising edge, before the block updates.
  // The result is checked before the input is predicted, so a word can never
  // meet its own expectation in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tau_now = cfg_time_constant;
      if (out_valid && !out_stall) begin
        seen.stamp = out_stamp_out;
        seen.val   = {out_filtered_3, out_filtered_2, out_filtered_1, out_filtered_0};
        words_seen++;
        if (pending_smoothed.size() == 0) begin
          report("word with nothing expected", seen, seen);
        end else begin
          bit bad;
          due = pending_smoothed.pop_front();
          bad = (due.stamp != seen.stamp);
          for (int k = 0; k < CHANNELS; k++)
            if (due.val[k] != seen.val[k]) bad = 1'b1;
          if (bad) report("mismatch", due, seen);
        end
      end
      if (in_valid && !in_stall) begin
        predicted = smooth_vector(in_timestamp,
                                  {in_sample_3, in_sample_2, in_sample_1, in_sample_0});
        // typed rows carry their own answer; the predictor still steps
        pending_smoothed.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  initial begin
    logic [STAMP_W-1:0]                stamp_now, dt, base;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] x, last_x;
    logic [TAU_W-1:0]                  phase_tau [PHASES];
    int                                r, drain_cycles;

    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_time_constant = '0;
    in_valid          = 1'b0;
    in_timestamp      = '0;
    in_sample_0       = '0;
    in_sample_1       = '0;
    in_sample_2       = '0;
    in_sample_3       = '0;
    row_typed         = 1'b0;
    row_want          = '0;
    tau_now           = TAU_RESET;
    prev_stamp        = '0;
    for (int k = 0; k < CHANNELS; k++) held_y[k] = '0;

    // At reset tau is 1000 and the state is zero at time zero.
    // Same stamp as the stored one: gain 0, the zero state comes back.
    plan_row(0, 0, 32'h0000_0000, 32767, -32768, 1, -1, 1, 0, 0, 0, 0);
    plan_row(0, 0, 32'h0000_0000, -32768, 32767, -1, 1, 1, 0, 0, 0, 0);
    // dt equals tau: gain one half
    plan_row(0, 0, 32'h0000_03E8, 32767, -32768, 21845, -21846, 0, 0, 0, 0, 0);
    // huge forward step, then the stamp going backwards, then a wrap
    plan_row(0, 0, 32'hFFFF_FFFF, -32768, 32767, 0, -1, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'hFFFF_FF00, 32767, 32767, -32768, -32768, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h0000_0010, 0, -1, 32767, 1, 0, 0, 0, 0, 0);
    // tau 0 with dt > 0: output copies the input; with dt 0 it holds
    plan_row(1, 0, 32'h0000_0020, 32767, -32768, -1, 0, 1, 32767, -32768, -1, 0);
    plan_row(0, 0, 32'h0000_0020, 0, 0, 0, 0, 1, 32767, -32768, -1, 0);
    plan_row(0, 0, 32'h0000_0021, -32768, 32767, 255, -256, 1, -32768, 32767, 255, -256);
    plan_row(0, 0, 32'h0000_0021, 1, 2, 3, 4, 1, -32768, 32767, 255, -256);
    // largest tau: tiny steps round to gain 0, a step of tau gives one half
    plan_row(1, TAU_MAX, 32'h0000_0022, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h0100_0021, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h8100_0021, -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0);
    // smallest nonzero tau
    plan_row(1, 1, 32'h8100_0022, -32768, 32767, 12345, -12345, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h8100_0024, 32767, -32768, -21846, 21845, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h8100_0024, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(0, 0, 32'h8100_0027, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].set_tau) load_tau(plan[i].tau);
      push_word(plan[i].stamp, plan[i].x, plan[i].typed, plan[i].want);
    end

    // random phases, each at its own tau; the last one runs without idling
    phase_tau[0] = TAU_W'($urandom_range(2, 64));
    phase_tau[1] = TAU_MAX;
    phase_tau[2] = TAU_W'($urandom_range(100, 5000));
    phase_tau[3] = '0;
    phase_tau[4] = 24'd1;
    phase_tau[5] = TAU_W'($urandom_range(0, 24'hFF_FFFF));
    stamp_now = 32'h8100_0027;
    last_x    = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      load_tau(phase_tau[ph]);
      quiet = (ph == PHASES - 1);
      base = (phase_tau[ph] == '0) ? 32'd64 : {8'd0, phase_tau[ph]};
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // steps mostly on the scale of tau, with repeats, tiny steps and wild jumps
        r = $urandom_range(0, 99);
        if (r < 8)       dt = '0;
        else if (r < 20) dt = $urandom_range(1, 16);
        else if (r < 88) dt = $urandom_range(1, base * 4);
        else             dt = $urandom;
        stamp_now = stamp_now + dt;
        for (int k = 0; k < CHANNELS; k++) x[k] = pick_sample(last_x[k]);
        last_x = x;
        push_word(stamp_now, x, 1'b0, '0);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        if (!quiet && $urandom_range(0, 119) == 0) drain_results();
      end
    end

    // let the pipeline empty, then watch a while longer for stray words
    @(negedge clk);
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_smoothed.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (48) @(posedge clk);
    if (pending_smoothed.size() != 0) begin
      errors += pending_smoothed.size();
      $display("tb: %0d expected words never arrived", pending_smoothed.size());
    end

    $display("tb: %0d words sent (%0d with typed answers), %0d filtered words checked",
             words_sent, typed_sent, words_seen);
    $display("tb: %0d tau writes incl. 0, 1 and full scale; %0d errors", tau_writes, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
